// File: rtl/nwte_pkg.sv
// Shared types, constants and helpers for the NoC window TLB encoder.
// No dependencies; every RTL file in rtl/ imports this package.
package nwte_pkg;

	// Window layout
	localparam int unsigned SMALL_WINDOWS    = 156;
	localparam int unsigned MEDIUM_WINDOWS   = 10;
	localparam int unsigned LARGE_WINDOWS    = 20;
	localparam int unsigned NET_ADDRESS_BITS = 36;

	localparam int unsigned SHIFT_SMALL  = 20;
	localparam int unsigned SHIFT_MEDIUM = 21;
	localparam int unsigned SHIFT_LARGE  = 24;

	// Field widths
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned ADDR_W    = 64;
	localparam int unsigned COORD_W   = 6;
	localparam int unsigned ROUTE_W   = 29;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned WORD_W    = 45;
	localparam int unsigned REGOFF_W  = 11;
	localparam int unsigned BYTES_W   = 25;
	localparam int unsigned APER_W    = 29;
	localparam int unsigned SHIFT_W   = 5;
	localparam int unsigned BOUND_W   = 10;
	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 112;

	// Index range ends, two bits wider than the sums can reach
	localparam logic [BOUND_W-1:0] S_END = BOUND_W'(SMALL_WINDOWS);
	localparam logic [BOUND_W-1:0] M_END = BOUND_W'(SMALL_WINDOWS + MEDIUM_WINDOWS);
	localparam logic [BOUND_W-1:0] L_END =
		BOUND_W'(SMALL_WINDOWS + MEDIUM_WINDOWS + LARGE_WINDOWS);

	// Aperture bases of each window kind
	localparam logic [63:0] MEDIUM_BASE_FULL = 64'(SMALL_WINDOWS) << SHIFT_SMALL;
	localparam logic [63:0] LARGE_BASE_FULL  =
		MEDIUM_BASE_FULL + (64'(MEDIUM_WINDOWS) << SHIFT_MEDIUM);
	localparam logic [APER_W-1:0] MEDIUM_BASE = MEDIUM_BASE_FULL[APER_W-1:0];
	localparam logic [APER_W-1:0] LARGE_BASE  = LARGE_BASE_FULL[APER_W-1:0];

	typedef enum logic [1:0] {
		KIND_SMALL,
		KIND_MEDIUM,
		KIND_LARGE,
		KIND_INVALID
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_INDEX  = 2'd1,
		STATUS_MISALIGNED = 2'd2,
		STATUS_TOO_WIDE   = 2'd3
	} status_t;

	// Request as taken from the input stream
	typedef struct packed {
		logic [IDX_W-1:0]   window_index;
		logic [ADDR_W-1:0]  target_address;
		logic [COORD_W-1:0] x_last;
		logic [COORD_W-1:0] y_last;
		logic [COORD_W-1:0] x_first;
		logic [COORD_W-1:0] y_first;
		logic               network_select;
		logic               multicast;
		logic [1:0]         ordering_mode;
		logic               linked;
	} req_t;

	// After index decode
	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   local_idx;
		logic [ADDR_W-1:0]  addr;
		logic [ROUTE_W-1:0] routing;
	} dec_t;

	// After checks
	typedef struct packed {
		status_t                     status;
		kind_t                       kind;
		logic [NET_ADDRESS_BITS-1:0] page;
		logic [ROUTE_W-1:0]          routing;
		logic [REGOFF_W-1:0]         register_offset;
		logic [BYTES_W-1:0]          window_bytes;
		logic [APER_W-1:0]           aperture_offset;
	} chk_t;

	// Result item
	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   window_word;
		logic [REGOFF_W-1:0] register_offset;
		logic [BYTES_W-1:0]  window_bytes;
		logic [APER_W-1:0]   aperture_offset;
	} res_t;

	// log2 of the window size of a kind
	function automatic logic [SHIFT_W-1:0] kind_shift(kind_t kind);
		logic [SHIFT_W-1:0] s;
		unique case (kind)
			KIND_MEDIUM: s = SHIFT_W'(SHIFT_MEDIUM);
			KIND_LARGE:  s = SHIFT_W'(SHIFT_LARGE);
			default:     s = SHIFT_W'(SHIFT_SMALL);
		endcase
		return s;
	endfunction

	// Aperture byte offset of the first window of a kind
	function automatic logic [APER_W-1:0] kind_base(kind_t kind);
		logic [APER_W-1:0] b;
		unique case (kind)
			KIND_MEDIUM: b = MEDIUM_BASE;
			KIND_LARGE:  b = LARGE_BASE;
			default:     b = '0;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/nwte_decode.sv
// Stage 1: window index decode into kind and index within the kind.
// Depends on nwte_pkg.
module nwte_decode
	import nwte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  req_t req,
	output logic valid_s1,
	output dec_t dec_s1
);

	logic [BOUND_W-1:0] idx_w;
	logic [BOUND_W-1:0] first;
	kind_t              kind;

	// Range decode, lowest range wins
	always_comb begin
		idx_w = BOUND_W'(req.window_index);
		priority if (idx_w < S_END) begin
			kind  = KIND_SMALL;
			first = '0;
		end else if (idx_w < M_END) begin
			kind  = KIND_MEDIUM;
			first = S_END;
		end else if (idx_w < L_END) begin
			kind  = KIND_LARGE;
			first = M_END;
		end else begin
			kind  = KIND_INVALID;
			first = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			dec_s1.kind      <= kind;
			dec_s1.idx       <= req.window_index;
			dec_s1.local_idx <= IDX_W'(idx_w - first);
			dec_s1.addr      <= req.target_address;
			dec_s1.routing   <= {req.linked, req.ordering_mode, req.multicast,
				req.network_select, req.y_first, req.x_first, req.y_last, req.x_last};
		end
	end

endmodule

// File: rtl/nwte_check.sv
// Stage 2: alignment and width checks, size, register and aperture offsets.
// Depends on nwte_pkg.
module nwte_check
	import nwte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  dec_t dec,
	output logic valid_s2,
	output chk_t chk_s2
);

	logic [SHIFT_W-1:0] shift;
	logic [63:0]        size;
	logic               misaligned;
	logic               too_wide;
	status_t            status;
	logic [31:0]        local_bytes;

	always_comb begin
		shift       = kind_shift(dec.kind);
		size        = 64'd1 << shift;
		misaligned  = (dec.addr & (size - 64'd1)) != 64'd0;
		too_wide    = dec.addr[ADDR_W-1:NET_ADDRESS_BITS] != '0;
		local_bytes = 32'(dec.local_idx) << shift;
	end

	// Check order: index, then alignment, then width
	always_comb begin
		priority if (dec.kind == KIND_INVALID) begin
			status = STATUS_BAD_INDEX;
		end else if (misaligned) begin
			status = STATUS_MISALIGNED;
		end else if (too_wide) begin
			status = STATUS_TOO_WIDE;
		end else begin
			status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	// Everything but status, kind and routing is cleared on error
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			chk_s2.status  <= status;
			chk_s2.kind    <= dec.kind;
			chk_s2.routing <= dec.routing;
			if (status == STATUS_OK) begin
				chk_s2.page            <= dec.addr[NET_ADDRESS_BITS-1:0] >> shift;
				chk_s2.register_offset <= REGOFF_W'({dec.idx, 3'b000});
				chk_s2.window_bytes    <= size[BYTES_W-1:0];
				chk_s2.aperture_offset <= kind_base(dec.kind) + local_bytes[APER_W-1:0];
			end else begin
				chk_s2.page            <= '0;
				chk_s2.register_offset <= '0;
				chk_s2.window_bytes    <= '0;
				chk_s2.aperture_offset <= '0;
			end
		end
	end

endmodule

// File: rtl/nwte_pack.sv
// Stage 3: packs the window word, routing bits above the page number.
// Depends on nwte_pkg; its register is the output register of the block.
module nwte_pack
	import nwte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  chk_t chk,
	output logic valid_s3,
	output res_t res_s3
);

	logic [5:0]  route_pos;
	logic [63:0] word;

	// Routing starts where the page number of this window size ends
	always_comb begin
		route_pos = 6'(NET_ADDRESS_BITS) - 6'(kind_shift(chk.kind));
		word      = 64'(chk.page) | (64'(chk.routing) << route_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_s3.status          <= chk.status;
			res_s3.window_word     <= (chk.status == STATUS_OK) ? word[WORD_W-1:0] : '0;
			res_s3.register_offset <= chk.register_offset;
			res_s3.window_bytes    <= chk.window_bytes;
			res_s3.aperture_offset <= chk.aperture_offset;
		end
	end

endmodule

// File: rtl/noc_window_tlb_encoder.sv
// Top level of the NoC window TLB encoder: stream ports and stage control.
// Depends on nwte_pkg, nwte_decode, nwte_check and nwte_pack.
//
// Each request transfer programs one translation window and yields exactly one
// result transfer, in order, after passing the decode, check and pack stage
// registers. The block is a three-stage pipeline (index decode, checks and
// offsets, word packing) and takes one request every cycle while the output
// is not stalled; a stage moves on whenever the stage after it is empty or
// moving, so a stalled output fills the pipeline and then drops s_axis_tready
// without losing an item. The third stage register drives the output directly.
// Windows 0-155 are 1 MiB, 156-165 2 MiB and 166-185 16 MiB; other indices
// return a bad index status. On any error every result field other than
// status is zero. There is no state to initialise and no configuration.
module noc_window_tlb_encoder
	import nwte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// window_index[7:0], target_address[71:8], x_last[77:72], y_last[83:78],
	// x_first[89:84], y_first[95:90], network_select[96], multicast[97],
	// ordering_mode[99:98], linked[100], zero[103:101]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], window_word[46:2], register_offset[57:47],
	// window_bytes[82:58], aperture_offset[111:83]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	req_t req;
	dec_t dec_s1;
	chk_t chk_s2;
	res_t res_s3;
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	// Unpack request
	always_comb begin
		req.window_index   = s_axis_tdata[7:0];
		req.target_address = s_axis_tdata[71:8];
		req.x_last         = s_axis_tdata[77:72];
		req.y_last         = s_axis_tdata[83:78];
		req.x_first        = s_axis_tdata[89:84];
		req.y_first        = s_axis_tdata[95:90];
		req.network_select = s_axis_tdata[96];
		req.multicast      = s_axis_tdata[97];
		req.ordering_mode  = s_axis_tdata[99:98];
		req.linked         = s_axis_tdata[100];
	end

	// Stage enables: a stage loads when it is empty or its content moves on
	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	nwte_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv1),
		.in_valid (s_axis_tvalid),
		.req      (req),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	nwte_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv2),
		.in_valid (valid_s1),
		.dec      (dec_s1),
		.valid_s2 (valid_s2),
		.chk_s2   (chk_s2)
	);

	nwte_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv3),
		.in_valid (valid_s2),
		.chk      (chk_s2),
		.valid_s3 (valid_s3),
		.res_s3   (res_s3)
	);

	// Pack result
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {res_s3.aperture_offset, res_s3.window_bytes,
		res_s3.register_offset, res_s3.window_word, res_s3.status};

endmodule

// File: rtl/nwte_checker.sv
// Port-level checker for the NoC window TLB encoder, bound to the top level.
// Depends on nwte_pkg and noc_window_tlb_encoder.
module nwte_checker
	import nwte_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [STATUS_W-1:0] st;
	logic [WORD_W-1:0]   word;
	logic [REGOFF_W-1:0] roff;
	logic [BYTES_W-1:0]  bytes;
	logic [APER_W-1:0]   aper;
	logic                in_idle;

	assign st      = m_axis_tdata[1:0];
	assign word    = m_axis_tdata[46:2];
	assign roff    = m_axis_tdata[57:47];
	assign bytes   = m_axis_tdata[82:58];
	assign aper    = m_axis_tdata[111:83];
	assign in_idle = !s_axis_tvalid && (s_axis_tdata == s_axis_tdata);

	// A result held back keeps its valid and its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// An error result carries zeros in every field other than status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != STATUS_OK |->
			word == '0 && roff == '0 && bytes == '0 && aper == '0)
		else $error("error result not cleared");

	// A good result has one of the three window sizes and an aligned offset
	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == STATUS_OK |->
			(bytes == BYTES_W'(1 << SHIFT_SMALL) || bytes == BYTES_W'(1 << SHIFT_MEDIUM)
			|| bytes == BYTES_W'(1 << SHIFT_LARGE)) && roff[2:0] == 3'b000)
		else $error("bad window size or register offset");

	// Output never blocked and no input while the pipeline drains: no result may then appear
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_idle && m_axis_tready ##1 !s_axis_tvalid && m_axis_tready
			##1 !s_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("result appeared without a request");

endmodule

bind noc_window_tlb_encoder nwte_checker u_nwte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/window_result_checker.sv
// Checker for the NoC window TLB encoder: watches both stream channels,
// predicts each result from the accepted request and compares it field by field.
// Depends on nwte_pkg for widths, window layout constants and the status codes.
module window_result_checker
	import nwte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    failures,
	output int                    waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	res_t window_results_q[$];
	int   fail_count = 0;

	// Expected result of one request, from its packed transfer data
	function automatic res_t encode_window(logic [IN_DATA_W-1:0] d);
		logic [IDX_W-1:0]   idx;
		logic [ADDR_W-1:0]  addr;
		logic [ROUTE_W-1:0] routing;
		logic [63:0]        size;
		logic [63:0]        first;
		logic [63:0]        base;
		logic [63:0]        word;
		logic [63:0]        offset;
		logic [63:0]        aper;
		int unsigned        shift;
		res_t               r;
		idx     = d[7:0];
		addr    = d[71:8];
		routing = d[100:72];
		r       = '0;
		r.status = STATUS_OK;
		// window kind from the fixed index ranges
		if (idx < SMALL_WINDOWS) begin
			shift = SHIFT_SMALL;
			first = 64'd0;
			base  = 64'd0;
		end else if (idx < SMALL_WINDOWS + MEDIUM_WINDOWS) begin
			shift = SHIFT_MEDIUM;
			first = 64'(SMALL_WINDOWS);
			base  = 64'(SMALL_WINDOWS) << SHIFT_SMALL;
		end else if (idx < SMALL_WINDOWS + MEDIUM_WINDOWS + LARGE_WINDOWS) begin
			shift = SHIFT_LARGE;
			first = 64'(SMALL_WINDOWS + MEDIUM_WINDOWS);
			base  = (64'(SMALL_WINDOWS) << SHIFT_SMALL) +
				(64'(MEDIUM_WINDOWS) << SHIFT_MEDIUM);
		end else begin
			r.status = STATUS_BAD_INDEX;
			return r;
		end
		size = 64'd1 << shift;
		// alignment is checked before the address width
		if ((addr & (size - 64'd1)) != 64'd0) begin
			r.status = STATUS_MISALIGNED;
			return r;
		end
		if (addr >= (64'd1 << NET_ADDRESS_BITS)) begin
			r.status = STATUS_TOO_WIDE;
			return r;
		end
		word   = (addr >> shift) | (64'(routing) << (NET_ADDRESS_BITS - shift));
		offset = 64'(idx) * 64'd8;
		aper   = base + size * (64'(idx) - first);
		r.window_word     = word[WORD_W-1:0];
		r.register_offset = offset[REGOFF_W-1:0];
		r.window_bytes    = size[BYTES_W-1:0];
		r.aperture_offset = aper[APER_W-1:0];
		return r;
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, msg);
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got)
			note_failure($sformatf("%s expected %h, got %h", name, want, got));
	endfunction

	// Sample both channels at the rising edge; queue on request, compare on result
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			failures <= 0;
			waiting  <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				window_results_q.push_back(encode_window(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (window_results_q.size() == 0) begin
					note_failure($sformatf("result transfer with nothing expected, data %h",
						m_axis_tdata));
				end else begin
					want = window_results_q.pop_front();
					compare_field("status", 64'(want.status), 64'(m_axis_tdata[1:0]));
					compare_field("window_word", 64'(want.window_word),
						64'(m_axis_tdata[46:2]));
					compare_field("register_offset", 64'(want.register_offset),
						64'(m_axis_tdata[57:47]));
					compare_field("window_bytes", 64'(want.window_bytes),
						64'(m_axis_tdata[82:58]));
					compare_field("aperture_offset", 64'(want.aperture_offset),
						64'(m_axis_tdata[111:83]));
				end
			end
			failures <= fail_count;
			waiting  <= window_results_q.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the NoC window TLB encoder testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on nwte_pkg, noc_window_tlb_encoder and window_result_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import nwte_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int ITEMS_PER_PHASE  = 180;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int DRAIN_CYCLES     = 8;
	localparam logic [63:0] NET_SPAN = 64'd1 << NET_ADDRESS_BITS;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int failures;
	int waiting;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	bit hold_off_go = 1'b0;
	bit hold_off_done = 1'b0;

	int send_idle_set[4] = '{0, 74, 0, 35};
	int stall_set[4]     = '{0, 0, 74, 35};

	noc_window_tlb_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	window_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.failures      (failures),
		.waiting       (waiting)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off to fill the pipeline
	always begin
		@(negedge clk);
		if (hold_off_go && !hold_off_done) begin
			m_axis_tready <= 1'b0;
			repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			hold_off_done = 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog: cycles in which neither channel completes a transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [IN_DATA_W-1:0] make_request(logic [7:0] idx, logic [63:0] addr,
		logic [ROUTE_W-1:0] routing);
		return {3'b000, routing, addr, idx};
	endfunction

	// Mostly valid, aligned requests; the rest misaligned, too wide or unmapped
	function automatic logic [IN_DATA_W-1:0] random_request();
		logic [7:0]  idx;
		logic [63:0] addr;
		int unsigned shift;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			idx = 8'($urandom_range(0, SMALL_WINDOWS - 1));
		else if (pick < 65)
			idx = 8'($urandom_range(SMALL_WINDOWS, SMALL_WINDOWS + MEDIUM_WINDOWS - 1));
		else if (pick < 90)
			idx = 8'($urandom_range(SMALL_WINDOWS + MEDIUM_WINDOWS,
				SMALL_WINDOWS + MEDIUM_WINDOWS + LARGE_WINDOWS - 1));
		else
			idx = 8'($urandom_range(SMALL_WINDOWS + MEDIUM_WINDOWS + LARGE_WINDOWS, 255));
		if (idx < SMALL_WINDOWS)
			shift = SHIFT_SMALL;
		else if (idx < SMALL_WINDOWS + MEDIUM_WINDOWS)
			shift = SHIFT_MEDIUM;
		else
			shift = SHIFT_LARGE;
		addr = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 70)
			addr = addr & (NET_SPAN - (64'd1 << shift));
		else if (pick < 80)
			addr = (addr & (NET_SPAN - 64'd1)) | (64'd1 << $urandom_range(0, shift - 1));
		else if (pick < 90)
			addr = (addr & ~((64'd1 << shift) - 64'd1)) |
				(64'd1 << $urandom_range(NET_ADDRESS_BITS, 63));
		return make_request(idx, addr, ROUTE_W'($urandom));
	endfunction

	// One request transfer; valid is held between back-to-back transfers
	task automatic send_request(logic [IN_DATA_W-1:0] d);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Range ends, every window kind, each error and its priority
		send_request(make_request(8'd0, 64'h0, '0));
		send_request(make_request(8'd155, 64'hF_FFF0_0000, '1));
		send_request(make_request(8'd156, 64'h20_0000, 29'h0AAA_AAAA));
		send_request(make_request(8'd165, 64'hF_FFE0_0000, 29'h1555_5555));
		send_request(make_request(8'd166, 64'h0, '1));
		send_request(make_request(8'd185, 64'hF_FF00_0000, 29'h0400_0000));
		send_request(make_request(8'd186, 64'h0, '0));
		send_request(make_request(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, '1));
		send_request(make_request(8'd10, 64'h8_0000, '0));
		send_request(make_request(8'd160, 64'h10_0000, '0));
		send_request(make_request(8'd170, 64'h80_0000, '0));
		send_request(make_request(8'd20, 64'hFFFF_FFFF_FFFF_FFFF, '0));
		send_request(make_request(8'd30, 64'h10_0000_0000, '0));
		send_request(make_request(8'd40, 64'hFFFF_FFFF_FFF0_0000, '1));
		send_request(make_request(8'd180, 64'hFFFF_FFFF_FF00_0000, '0));
		send_request(make_request(8'd100, 64'h1, '0));
		send_request(make_request(8'd1, 64'h10_0000, 29'h0800_0000));
		send_request(make_request(8'd2, 64'h20_0000, 29'h0C00_0000));
		send_request(make_request(8'd157, 64'h40_0000, 29'h0200_0000));
		send_request(make_request(8'd167, 64'h100_0000, 29'h1100_0000));

		// Random requests under each idling mix
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle_set[phase];
			stall_pct     = stall_set[phase];
			repeat (ITEMS_PER_PHASE)
				send_request(random_request());
		end

		// Long output hold-off while requests keep coming
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_off_go   = 1'b1;
		repeat (PRESSURE_ITEMS)
			send_request(random_request());

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/nwte_pkg.sv
rtl/nwte_decode.sv
rtl/nwte_check.sv
rtl/nwte_pack.sv
rtl/noc_window_tlb_encoder.sv
rtl/nwte_checker.sv
tb/window_result_checker.sv
tb/testbench.sv
